/* hw/rtl/acs_pkg.sv */
// Shared types, constants and lookup functions of the Arabic contextual shaper.
// No dependencies; used by acs_front, acs_queue, acs_back and the top level.
`timescale 1ns / 1ps

package acs_pkg;

    localparam logic [15:0] LETTER_LO = 16'h0621;
    localparam logic [15:0] LETTER_HI = 16'h064A;
    localparam logic [15:0] LAM       = 16'h0644;
    localparam logic [15:0] TATWEEL   = 16'h0640;
    localparam logic [15:0] ALEF_MADDA = 16'h0622;
    localparam logic [15:0] ALEF_HAMZA_ABOVE = 16'h0623;
    localparam logic [15:0] ALEF_HAMZA_BELOW = 16'h0625;
    localparam logic [15:0] ALEF       = 16'h0627;
    localparam logic [15:0] LIG_MADDA  = 16'hFEF5;
    localparam logic [15:0] LIG_HAMZA_ABOVE = 16'hFEF7;
    localparam logic [15:0] LIG_HAMZA_BELOW = 16'hFEF9;
    localparam logic [15:0] LIG_ALEF   = 16'hFEFB;

    localparam int unsigned NUM_LETTERS = 42;

    // One row per letter, packed {medial, initial, final, isolated}
    localparam logic [63:0] FORM_ROWS [NUM_LETTERS] = '{
        64'hFE80_FE80_FE80_FE80, 64'hFE82_FE81_FE82_FE81,
        64'hFE84_FE83_FE84_FE83, 64'hFE86_FE85_FE86_FE85,
        64'hFE88_FE87_FE88_FE87, 64'hFE8C_FE8B_FE8A_FE89,
        64'hFE8E_FE8D_FE8E_FE8D, 64'hFE92_FE91_FE90_FE8F,
        64'hFE94_FE93_FE94_FE93, 64'hFE98_FE97_FE96_FE95,
        64'hFE9C_FE9B_FE9A_FE99, 64'hFEA0_FE9F_FE9E_FE9D,
        64'hFEA4_FEA3_FEA2_FEA1, 64'hFEA8_FEA7_FEA6_FEA5,
        64'hFEAA_FEA9_FEAA_FEA9, 64'hFEAC_FEAB_FEAC_FEAB,
        64'hFEAE_FEAD_FEAE_FEAD, 64'hFEB0_FEAF_FEB0_FEAF,
        64'hFEB4_FEB3_FEB2_FEB1, 64'hFEB8_FEB7_FEB6_FEB5,
        64'hFEBC_FEBB_FEBA_FEB9, 64'hFEC0_FEBF_FEBE_FEBD,
        64'hFEC4_FEC3_FEC2_FEC1, 64'hFEC8_FEC7_FEC6_FEC5,
        64'hFECC_FECB_FECA_FEC9, 64'hFED0_FECF_FECE_FECD,
        64'h063B_063B_063B_063B, 64'h063C_063C_063C_063C,
        64'h063D_063D_063D_063D, 64'h063E_063E_063E_063E,
        64'h063F_063F_063F_063F, 64'h0640_0640_0640_0640,
        64'hFED4_FED3_FED2_FED1, 64'hFED8_FED7_FED6_FED5,
        64'hFEDC_FEDB_FEDA_FED9, 64'hFEE0_FEDF_FEDE_FEDD,
        64'hFEE4_FEE3_FEE2_FEE1, 64'hFEE8_FEE7_FEE6_FEE5,
        64'hFEEC_FEEB_FEEA_FEE9, 64'hFEEE_FEED_FEEE_FEED,
        64'hFEF4_FEF3_FEF0_FEEF, 64'hFEF4_FEF3_FEF2_FEF1
    };

    typedef enum logic [0:0] {
        CMD_SHAPE,
        CMD_LIG
    } t_cmd_kind;

    // Work item handed from front to back. For CMD_LIG, unit_a is the alef
    // and sel_a[0] says the unit before the lam joins forward.
    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] unit_a;
        logic [1:0]  sel_a;
        logic        two;
        logic [15:0] unit_b;
        logic [1:0]  sel_b;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic held_valid;
    } t_front_status;

    typedef struct packed {
        logic phase;
    } t_back_status;

    // Joins to the following letter
    function automatic logic in_set_a(input logic [15:0] u);
        return (u == 16'h0626) || (u == 16'h0628) ||
               (u >= 16'h062A && u <= 16'h062E) ||
               (u >= 16'h0633 && u <= 16'h063A) ||
               (u >= TATWEEL && u <= 16'h0647) || (u == LETTER_HI);
    endfunction

    // Joins to the preceding letter
    function automatic logic in_set_b(input logic [15:0] u);
        return (u >= ALEF_MADDA && u <= 16'h063A) ||
               (u >= TATWEEL && u <= LETTER_HI);
    endfunction

    function automatic logic is_alef(input logic [15:0] u);
        return (u == ALEF_MADDA) || (u == ALEF_HAMZA_ABOVE) ||
               (u == ALEF_HAMZA_BELOW) || (u == ALEF);
    endfunction

    function automatic logic [15:0] lig_base(input logic [15:0] u);
        logic [15:0] r;
        unique case (u)
            ALEF_MADDA:       r = LIG_MADDA;
            ALEF_HAMZA_ABOVE: r = LIG_HAMZA_ABOVE;
            ALEF_HAMZA_BELOW: r = LIG_HAMZA_BELOW;
            default:          r = LIG_ALEF;
        endcase
        return r;
    endfunction

    // sel: bit 0 = neighbor before joins, bit 1 = neighbor after joins
    function automatic logic [15:0] shape_glyph(input logic [15:0] u,
                                                input logic [1:0]  sel);
        logic [15:0] diff;
        logic [63:0] row;
        logic [15:0] r;
        diff = u - LETTER_LO;
        row  = FORM_ROWS[diff[5:0]];
        if (u < LETTER_LO || u > LETTER_HI) begin
            r = u;
        end else begin
            unique case (sel)
                2'd0:    r = row[15:0];
                2'd1:    r = row[31:16];
                2'd2:    r = row[47:32];
                default: r = row[63:48];
            endcase
        end
        return r;
    endfunction

endpackage

/* hw/rtl/arabic_contextual_shaper.sv */
// A unit's glyph is known once its successor (or its own tlast) is accepted; its command
// is registered in the queue, then the glyph enters the output register when it is free.
// Throughput: one input beat per cycle while the queue is not full; the queue absorbs
// output stalls. A string ending on a shaped pair yields two glyphs, sent one after the other.
// Reset: synchronous i_rst_n low clears held/previous unit, queue and output valid.
`timescale 1ns / 1ps

module arabic_contextual_shaper #(
    parameter int QDEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  logic        s_axis_tlast,   // last_unit
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] glyph_code
    output logic        m_axis_tlast    // last_glyph
);

    acs_pkg::t_cmd          front_cmd;
    acs_pkg::t_cmd          q_head;
    acs_pkg::t_q_status     q_status;
    acs_pkg::t_front_status front_status;
    acs_pkg::t_back_status  back_status;
    logic                   push;
    logic                   pop;

    // Front: holds one unit of lookahead plus the original previous unit,
    // decides joins (set A before, set B after) and lam-alef folding.
    acs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_unit     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .o_status   (front_status)
    );

    // Decouples classification from glyph output so either side can stall.
    acs_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    // Back: table lookup of presentation forms, ligature codes, output register.
    acs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_glyph    (m_axis_tdata),
        .o_last     (m_axis_tlast),
        .o_status   (back_status)
    );

    // A string end always leaves the front with nothing held
    a_end_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !front_status.held_valid)
        else $error("unit still held after string end");

    // Second glyph of a pair needs its command still at the queue head
    a_phase_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.phase |-> (q_status.valid && q_head.two))
        else $error("back end in second-glyph phase without a pair command");

    // A full queue must throttle the input side
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> (!s_axis_tready && q_status.valid))
        else $error("input accepted while queue full");

endmodule

/* hw/rtl/acs_front.sv */
// Front end: accepts code units, tracks held/previous unit, classifies joins
// and lam-alef pairs into commands. Depends on acs_pkg.
`timescale 1ns / 1ps

module acs_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [15:0]            i_unit,
    input  logic                   i_last,
    input  acs_pkg::t_q_status     i_q_status,
    output logic                   o_push,
    output acs_pkg::t_cmd          o_cmd,
    output acs_pkg::t_front_status o_status
);

    logic [15:0] r_prev_unit, n_prev_unit;
    logic [15:0] r_held_unit, n_held_unit;
    logic        r_held_valid, n_held_valid;
    logic        accept;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign o_status.held_valid = r_held_valid;

    always_comb begin
        n_prev_unit  = r_prev_unit;
        n_held_unit  = r_held_unit;
        n_held_valid = r_held_valid;
        o_push       = 1'b0;
        o_cmd        = '0;
        o_cmd.kind   = acs_pkg::CMD_SHAPE;
        if (accept) begin
            priority if (!r_held_valid) begin
                if (i_last) begin
                    o_push       = 1'b1;
                    o_cmd.unit_a = i_unit;
                    o_cmd.sel_a  = {1'b0, acs_pkg::in_set_a(r_prev_unit)};
                    o_cmd.last   = 1'b1;
                    n_prev_unit  = '0;
                end else begin
                    n_held_unit  = i_unit;
                    n_held_valid = 1'b1;
                end
            end else if (r_held_unit == acs_pkg::LAM && acs_pkg::is_alef(i_unit)) begin
                // alef folds into the lam; it still counts as previous unit
                o_push       = 1'b1;
                o_cmd.kind   = acs_pkg::CMD_LIG;
                o_cmd.unit_a = i_unit;
                o_cmd.sel_a  = {1'b0, acs_pkg::in_set_a(r_prev_unit)};
                o_cmd.last   = i_last;
                n_held_valid = 1'b0;
                n_held_unit  = '0;
                n_prev_unit  = i_last ? 16'h0000 : i_unit;
            end else begin
                o_push       = 1'b1;
                o_cmd.unit_a = r_held_unit;
                o_cmd.sel_a  = {acs_pkg::in_set_b(i_unit), acs_pkg::in_set_a(r_prev_unit)};
                if (i_last) begin
                    o_cmd.two    = 1'b1;
                    o_cmd.unit_b = i_unit;
                    o_cmd.sel_b  = {1'b0, acs_pkg::in_set_a(r_held_unit)};
                    o_cmd.last   = 1'b1;
                    n_prev_unit  = '0;
                    n_held_unit  = '0;
                    n_held_valid = 1'b0;
                end else begin
                    n_prev_unit = r_held_unit;
                    n_held_unit = i_unit;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_unit  <= '0;
            r_held_unit  <= '0;
            r_held_valid <= 1'b0;
        end else begin
            r_prev_unit  <= n_prev_unit;
            r_held_unit  <= n_held_unit;
            r_held_valid <= n_held_valid;
        end
    end

endmodule

/* hw/rtl/acs_queue.sv */
// Short command queue between front and back of the shaper.
// Depends on acs_pkg for the command type.
`timescale 1ns / 1ps

module acs_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  acs_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output acs_pkg::t_cmd      o_head,
    output acs_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    acs_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_head         = r_mem[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && o_status.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* hw/rtl/acs_back.sv */
// Back end: turns queued commands into glyph beats through the form table,
// one glyph per cycle while the output is free, into a registered output. Depends on acs_pkg.
`timescale 1ns / 1ps

module acs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  acs_pkg::t_cmd         i_head,
    input  acs_pkg::t_q_status    i_q_status,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [15:0]           o_glyph,
    output logic                  o_last,
    output acs_pkg::t_back_status o_status
);

    logic        r_valid, n_valid;
    logic        r_phase, n_phase;
    logic [15:0] r_glyph, n_glyph;
    logic        r_last, n_last;
    logic        out_free;

    assign out_free = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_glyph  = r_glyph;
    assign o_last   = r_last;
    assign o_status.phase = r_phase;

    always_comb begin
        n_valid = r_valid;
        n_phase = r_phase;
        n_glyph = r_glyph;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (out_free) begin
            n_valid = i_q_status.valid;
            if (i_q_status.valid) begin
                priority if (r_phase) begin
                    n_glyph = acs_pkg::shape_glyph(i_head.unit_b, i_head.sel_b);
                    n_last  = i_head.last;
                    n_phase = 1'b0;
                    o_pop   = 1'b1;
                end else if (i_head.two) begin
                    // first of a string-end pair; keep the command for the second
                    n_glyph = acs_pkg::shape_glyph(i_head.unit_a, i_head.sel_a);
                    n_last  = 1'b0;
                    n_phase = 1'b1;
                end else if (i_head.kind == acs_pkg::CMD_LIG) begin
                    n_glyph = acs_pkg::lig_base(i_head.unit_a) + {15'd0, i_head.sel_a[0]};
                    n_last  = i_head.last;
                    o_pop   = 1'b1;
                end else begin
                    n_glyph = acs_pkg::shape_glyph(i_head.unit_a, i_head.sel_a);
                    n_last  = i_head.last;
                    o_pop   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_glyph <= n_glyph;
        r_last  <= n_last;
    end

endmodule
